// ----- sv/kermit_crc32_link_framer_macros.svh -----
// Assertion macros used by the framer's top-level RTL file.
`ifndef KERMIT_CRC32_LINK_FRAMER_MACROS_SVH
`define KERMIT_CRC32_LINK_FRAMER_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define KCRC_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition holds in the cycle after the trigger.
`define KCRC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- sv/kcrc_pkg.sv -----
// Types, constants and the CRC-32 byte update shared by the framer modules.
package kcrc_pkg;

  localparam logic       OP_HEADER = 1'b0;
  localparam logic       OP_DATA   = 1'b1;

  localparam logic [7:0]  SYNC_HI    = 8'h57;
  localparam logic [7:0]  SYNC_LO    = 8'hA1;
  localparam logic [7:0]  MARK_RESET = 8'h01;
  localparam logic [7:0]  LEN_BIAS   = 8'd34;
  localparam logic [7:0]  PLEN_BIAS  = 8'd5;
  localparam logic [7:0]  CHAR_BIAS  = 8'd32;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

  typedef struct packed {
    logic        operation;
    logic [7:0]  access_point;
    logic [3:0]  frame_priority;
    logic [15:0] node_id;
    logic [7:0]  sequence_number;
    logic [7:0]  packet_type;
    logic [6:0]  data_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       frame_end;
  } out_t;

  // Status of the framing core, watched at the top level.
  typedef struct packed {
    logic hold_valid;
    logic in_frame;
  } core_stat_t;

  // Byte positions within the results of one item.
  typedef enum logic [4:0] {
    SLOT_SYNC_HI = 5'd0,
    SLOT_SYNC_LO = 5'd1,
    SLOT_SAP     = 5'd2,
    SLOT_PRIO    = 5'd3,
    SLOT_NODE_LO = 5'd4,
    SLOT_NODE_HI = 5'd5,
    SLOT_PLEN_LO = 5'd6,
    SLOT_PLEN_HI = 5'd7,
    SLOT_MARK    = 5'd8,
    SLOT_LEN     = 5'd9,
    SLOT_SEQ     = 5'd10,
    SLOT_TYPE    = 5'd11,
    SLOT_CHK     = 5'd12,
    SLOT_CRC0    = 5'd13,
    SLOT_CRC1    = 5'd14,
    SLOT_CRC2    = 5'd15,
    SLOT_CRC3    = 5'd16,
    SLOT_DATA    = 5'd17
  } slot_t;

  // Reflected CRC-32 over one byte; flattens to an XOR network.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/kermit_crc32_link_framer.sv -----
// Top level of the Kermit link framer with CRC-32 trailer.
//
// Requests arrive on the item channel (item_valid / item_ready / item). A
// header request opens a frame; data requests each carry one payload byte.
// Wire bytes leave on the tx channel (tx_valid / tx_ready / tx), one byte per
// cycle while tx_ready is high, with frame_end set on the last CRC byte.
// A request is registered when accepted, and its bytes are registered again
// in the output register before they appear on tx. A header request sends
// 12 bytes (17 with an empty payload), a data request 1 byte, and the last
// data request of a frame 6 bytes (byte, checksum, four CRC bytes). Data
// requests outside a frame are retired with no output.
// One request is held while its bytes are sequenced, so a new request is
// taken in the same cycle the last byte of the previous one is emitted.
// The cfg channel writes the inner start mark; it is always ready and should
// be used only while the framer is idle.
// Reset returns the mark to 0x01, closes any open frame and empties both
// the held request and the output register.
// When tx_valid is set and tx_ready low, the output byte holds, the sequencer
// stops, and item_ready falls once the held request still has bytes to send.
`include "kermit_crc32_link_framer_macros.svh"

module kermit_crc32_link_framer #(
  parameter int MAX_DATA = 91
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data,
  input  logic            item_valid,
  output logic            item_ready,
  input  kcrc_pkg::item_t item,
  output logic            tx_valid,
  input  logic            tx_ready,
  output kcrc_pkg::out_t  tx
);

  logic                 [7:0] mark_char;
  logic                 emit_valid;
  logic                 emit_ok;
  kcrc_pkg::out_t       emit;
  kcrc_pkg::core_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_char <= kcrc_pkg::MARK_RESET;
    end else if (cfg_valid) begin
      mark_char <= cfg_data;
    end
  end

  kcrc_core #(
    .MAX_DATA (MAX_DATA)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .mark_char  (mark_char),
    .emit_ok    (emit_ok),
    .emit_valid (emit_valid),
    .emit       (emit),
    .stat       (stat)
  );

  kcrc_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit       (emit),
    .emit_ok    (emit_ok),
    .tx_valid   (tx_valid),
    .tx_ready   (tx_ready),
    .tx         (tx)
  );

  `KCRC_ASSERT_NOW(a_emit_needs_request, emit_valid, stat.hold_valid, "byte emitted with no request held")
  `KCRC_ASSERT_NEXT(a_frame_closes, emit_valid && emit_ok && emit.frame_end, !stat.in_frame, "frame still open after its last CRC byte")
  `KCRC_ASSERT_NEXT(a_stalled_byte_holds, emit_valid && !emit_ok, emit_valid && $stable(emit), "sequencer moved while its byte was stalled")

endmodule

// ----- sv/kcrc_core.sv -----
// Framing core: item register, byte sequencer, checksum and CRC state.
module kcrc_core #(
  parameter int MAX_DATA = 91
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  kcrc_pkg::item_t        item,
  output logic                   item_ready,
  input  logic [7:0]             mark_char,
  input  logic                   emit_ok,
  output logic                   emit_valid,
  output kcrc_pkg::out_t         emit,
  output kcrc_pkg::core_stat_t   stat
);

  logic            hold_valid;
  kcrc_pkg::item_t hold;
  logic [4:0]      pos;
  logic            in_frame;
  logic [6:0]      bytes_left;
  logic [7:0]      check_sum;
  logic [31:0]     crc_reg;

  kcrc_pkg::slot_t slot;
  logic [6:0]      dlen_c;
  logic [7:0]      dlen_b;
  logic [7:0]      chk;
  logic [31:0]     crc_out;
  logic [7:0]      wire_byte;
  logic            drop;
  logic            last;
  logic            fire;
  logic            release_item;

  always_comb begin
    if (hold.operation == kcrc_pkg::OP_DATA) begin
      slot = (pos == 5'd0) ? kcrc_pkg::SLOT_DATA
                           : kcrc_pkg::slot_t'(pos + 5'(kcrc_pkg::SLOT_CHK) - 5'd1);
    end else begin
      slot = kcrc_pkg::slot_t'(pos);
    end
  end

  assign dlen_c  = (int'(hold.data_length) > MAX_DATA) ? 7'(MAX_DATA) : hold.data_length;
  assign dlen_b  = {1'b0, dlen_c};
  // Kermit checksum folds the top two bits back in before the 6-bit mask.
  assign chk     = ((check_sum + {6'd0, check_sum[7:6]}) & 8'h3F) + kcrc_pkg::CHAR_BIAS;
  assign crc_out = crc_reg ^ kcrc_pkg::CRC_INIT;

  always_comb begin
    case (slot)
      kcrc_pkg::SLOT_SYNC_HI: wire_byte = kcrc_pkg::SYNC_HI;
      kcrc_pkg::SLOT_SYNC_LO: wire_byte = kcrc_pkg::SYNC_LO;
      kcrc_pkg::SLOT_SAP:     wire_byte = hold.access_point;
      kcrc_pkg::SLOT_PRIO:    wire_byte = {4'h0, hold.frame_priority};
      kcrc_pkg::SLOT_NODE_LO: wire_byte = hold.node_id[7:0];
      kcrc_pkg::SLOT_NODE_HI: wire_byte = hold.node_id[15:8];
      kcrc_pkg::SLOT_PLEN_LO: wire_byte = dlen_b + kcrc_pkg::PLEN_BIAS;
      kcrc_pkg::SLOT_PLEN_HI: wire_byte = 8'h00;
      kcrc_pkg::SLOT_MARK:    wire_byte = mark_char;
      kcrc_pkg::SLOT_LEN:     wire_byte = dlen_b + kcrc_pkg::LEN_BIAS;
      kcrc_pkg::SLOT_SEQ:     wire_byte = {2'b00, hold.sequence_number[5:0]} + kcrc_pkg::CHAR_BIAS;
      kcrc_pkg::SLOT_TYPE:    wire_byte = hold.packet_type;
      kcrc_pkg::SLOT_CHK:     wire_byte = chk;
      kcrc_pkg::SLOT_CRC0:    wire_byte = crc_out[7:0];
      kcrc_pkg::SLOT_CRC1:    wire_byte = crc_out[15:8];
      kcrc_pkg::SLOT_CRC2:    wire_byte = crc_out[23:16];
      kcrc_pkg::SLOT_CRC3:    wire_byte = crc_out[31:24];
      kcrc_pkg::SLOT_DATA:    wire_byte = hold.data_byte;
      default:                wire_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (hold.operation == kcrc_pkg::OP_DATA) begin
      last = (slot == kcrc_pkg::SLOT_DATA) ? (bytes_left > 7'd1)
                                           : (slot == kcrc_pkg::SLOT_CRC3);
    end else if (dlen_c != 7'd0) begin
      last = (slot == kcrc_pkg::SLOT_TYPE);
    end else begin
      last = (slot == kcrc_pkg::SLOT_CRC3);
    end
  end

  // A data byte outside a frame produces nothing and is simply retired.
  assign drop         = (hold.operation == kcrc_pkg::OP_DATA) && !in_frame;
  assign emit_valid   = hold_valid && !drop;
  assign fire         = emit_valid && emit_ok;
  assign release_item = hold_valid && (drop || (fire && last));
  assign item_ready   = !hold_valid || release_item;

  assign emit.wire_byte = wire_byte;
  assign emit.frame_end = (slot == kcrc_pkg::SLOT_CRC3);

  assign stat.hold_valid = hold_valid;
  assign stat.in_frame   = in_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pos        <= 5'd0;
    end else begin
      if (item_ready) begin
        hold_valid <= item_valid;
      end
      if (release_item) begin
        pos <= 5'd0;
      end else if (fire) begin
        pos <= pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= 7'd0;
      check_sum  <= 8'd0;
      crc_reg    <= kcrc_pkg::CRC_INIT;
    end else if (fire) begin
      case (slot)
        kcrc_pkg::SLOT_MARK: begin
          check_sum <= 8'd0;
          crc_reg   <= kcrc_pkg::crc32_byte(kcrc_pkg::CRC_INIT, mark_char);
        end
        kcrc_pkg::SLOT_LEN, kcrc_pkg::SLOT_SEQ: begin
          check_sum <= check_sum + wire_byte;
          crc_reg   <= kcrc_pkg::crc32_byte(crc_reg, wire_byte);
        end
        kcrc_pkg::SLOT_TYPE: begin
          check_sum  <= check_sum + wire_byte;
          crc_reg    <= kcrc_pkg::crc32_byte(crc_reg, wire_byte);
          in_frame   <= (dlen_c != 7'd0);
          bytes_left <= dlen_c;
        end
        kcrc_pkg::SLOT_DATA: begin
          check_sum <= check_sum + wire_byte;
          crc_reg   <= kcrc_pkg::crc32_byte(crc_reg, wire_byte);
          if (bytes_left != 7'd0) begin
            bytes_left <= bytes_left - 7'd1;
          end
        end
        kcrc_pkg::SLOT_CHK: begin
          crc_reg <= kcrc_pkg::crc32_byte(crc_reg, chk);
        end
        kcrc_pkg::SLOT_CRC3: begin
          in_frame   <= 1'b0;
          bytes_left <= 7'd0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/kcrc_out_reg.sv -----
// Output register of the wire byte stream.
module kcrc_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           emit_valid,
  input  kcrc_pkg::out_t emit,
  output logic           emit_ok,
  output logic           tx_valid,
  input  logic           tx_ready,
  output kcrc_pkg::out_t tx
);

  assign emit_ok = !tx_valid || tx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (emit_valid && emit_ok) begin
      tx_valid <= 1'b1;
    end else if (tx_ready) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ok) begin
      tx <= emit;
    end
  end

endmodule
